/* rtl/qrs_pkg.sv */
// qrs_pkg: widths, stage payload types and class codes for the quadratic
// root solver. No dependencies; every other file imports it.
package qrs_pkg;

  localparam int COEF_BITS = 16;
  localparam int FRAC_BITS = 16;
  localparam int CLS_W     = 3;
  localparam int VAL_W     = 34;

  localparam int PROD_W    = 2 * COEF_BITS;
  localparam int DELTA_W   = 2 * COEF_BITS + 4;
  localparam int D_W       = 2 * COEF_BITS + 2;
  localparam int X_W       = D_W + 2 * FRAC_BITS;
  localparam int SQ_PAIRS  = X_W / 2;
  localparam int ROOT_W    = SQ_PAIRS;
  localparam int REM_W     = ROOT_W + 3;
  localparam int SQ_STEPS  = 3;
  localparam int SQ_STAGES = (SQ_PAIRS + SQ_STEPS - 1) / SQ_STEPS;

  localparam int N_W        = ROOT_W + 3;
  localparam int DEN_W      = COEF_BITS + 1;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = N_W / DIV_STEPS;

  typedef enum logic [CLS_W-1:0] {
    CLS_INFINITE = 3'd0,
    CLS_NONE     = 3'd1,
    CLS_LINEAR   = 3'd2,
    CLS_DOUBLE   = 3'd3,
    CLS_TWO_REAL = 3'd4,
    CLS_COMPLEX  = 3'd5
  } qrs_class_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] a;
    logic signed [COEF_BITS-1:0] b;
    logic signed [COEF_BITS-1:0] c;
  } qrs_coef_t;

  typedef struct packed {
    qrs_class_t       cls;
    qrs_coef_t        coef;
    logic [D_W-1:0]   d;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0] rem;
  } qrs_sq_t;

  typedef struct packed {
    logic [N_W-1:0]   nq;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic             neg;
  } qrs_lane_t;

  typedef struct packed {
    qrs_class_t cls;
    qrs_lane_t  lx;
    qrs_lane_t  ly;
  } qrs_dv_t;

endpackage

/* rtl/qrs_in_if.sv */
// qrs_in_if: request channel carrying one coefficient set.
// Depends on qrs_pkg for the coefficient width.
interface qrs_in_if;
  import qrs_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [COEF_BITS-1:0] coef_a;
  logic signed [COEF_BITS-1:0] coef_b;
  logic signed [COEF_BITS-1:0] coef_c;
  modport source(output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink(input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

/* rtl/qrs_out_if.sv */
// qrs_out_if: result channel carrying class code and two fixed-point values.
// Depends on qrs_pkg for the field widths.
interface qrs_out_if;
  import qrs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CLS_W-1:0]        root_class;
  logic signed [VAL_W-1:0] first_value;
  logic signed [VAL_W-1:0] second_value;
  modport source(output valid, output root_class, output first_value,
                 output second_value, input ready);
  modport sink(input valid, input root_class, input first_value,
               input second_value, output ready);
endinterface

/* rtl/qrs_front.sv */
// qrs_front: two stages, products b*b and a*c, then discriminant and class.
// Depends on qrs_pkg.
module qrs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qrs_pkg::qrs_coef_t in_coef,
  output logic               out_valid,
  input  logic               out_ready,
  output qrs_pkg::qrs_sq_t   out_sq
);
  import qrs_pkg::*;

  logic                     va_r;
  qrs_coef_t                coef_r;
  logic signed [PROD_W-1:0] bb_r, bb_nxt;
  logic signed [PROD_W-1:0] ac_r, ac_nxt;
  logic                     vb_r;
  qrs_sq_t                  sq_r, sq_nxt;
  logic                     a_ready;
  logic signed [DELTA_W-1:0] delta;
  logic [DELTA_W-1:0]       dabs;

  assign a_ready  = !vb_r || out_ready;
  assign in_ready = !va_r || a_ready;
  assign bb_nxt   = in_coef.b * in_coef.b;
  assign ac_nxt   = in_coef.a * in_coef.c;

  always_comb begin
    delta = DELTA_W'(bb_r) - (DELTA_W'(ac_r) <<< 2);
    dabs  = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);
    sq_nxt      = '0;
    sq_nxt.coef = coef_r;
    sq_nxt.d    = dabs[D_W-1:0];
    if (coef_r.a == '0 && coef_r.b == '0 && coef_r.c == '0) begin
      sq_nxt.cls = CLS_INFINITE;
    end else if (coef_r.a == '0 && coef_r.b == '0) begin
      sq_nxt.cls = CLS_NONE;
    end else if (coef_r.a == '0) begin
      sq_nxt.cls = CLS_LINEAR;
    end else if (delta == '0) begin
      sq_nxt.cls = CLS_DOUBLE;
    end else if (!delta[DELTA_W-1]) begin
      sq_nxt.cls = CLS_TWO_REAL;
    end else begin
      sq_nxt.cls = CLS_COMPLEX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (in_ready) va_r <= in_valid;
      if (a_ready) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      coef_r <= in_coef;
      bb_r   <= bb_nxt;
      ac_r   <= ac_nxt;
    end
    if (va_r && a_ready) sq_r <= sq_nxt;
  end

  assign out_valid = vb_r;
  assign out_sq    = sq_r;

endmodule

/* rtl/qrs_sqrt_stage.sv */
// qrs_sqrt_stage: a few bit-pair iterations of the restoring square root.
// Depends on qrs_pkg.
module qrs_sqrt_stage #(
  parameter int TOP_PAIR = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  qrs_pkg::qrs_sq_t in_sq,
  output logic             out_valid,
  input  logic             out_ready,
  output qrs_pkg::qrs_sq_t out_sq
);
  import qrs_pkg::*;

  logic              v_r;
  qrs_sq_t           sq_r, sq_nxt;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    logic [X_W-1:0]    x;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
    logic [REM_W-1:0]  r4;
    logic [REM_W-1:0]  trial;
    logic [1:0]        pair;
    int                j;
    x    = {in_sq.d, {(2 * FRAC_BITS){1'b0}}};
    root = in_sq.root;
    rem  = in_sq.rem;
    for (int k = 0; k < SQ_STEPS; k++) begin
      j     = TOP_PAIR - k;
      pair  = (j >= 0 && j < SQ_PAIRS) ? x[2*j +: 2] : 2'b00;
      r4    = {rem[REM_W-3:0], pair};
      trial = REM_W'({root, 2'b01});
      if (r4 >= trial) begin
        rem  = r4 - trial;
        root = {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  = r4;
        root = {root[ROOT_W-2:0], 1'b0};
      end
    end
    sq_nxt      = in_sq;
    sq_nxt.root = root;
    sq_nxt.rem  = rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (in_ready) v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) sq_r <= sq_nxt;
  end

  assign out_valid = v_r;
  assign out_sq    = sq_r;

endmodule

/* rtl/qrs_div_stage.sv */
// qrs_div_stage: a few restoring division steps on two magnitude lanes.
// Depends on qrs_pkg.
module qrs_div_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  qrs_pkg::qrs_dv_t in_dv,
  output logic             out_valid,
  input  logic             out_ready,
  output qrs_pkg::qrs_dv_t out_dv
);
  import qrs_pkg::*;

  logic    v_r;
  qrs_dv_t dv_r, dv_nxt;

  function automatic qrs_lane_t div_steps(input qrs_lane_t l);
    qrs_lane_t     o;
    logic [DEN_W:0] t;
    o = l;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t    = {o.rem, o.nq[N_W-1]};
      o.nq = {o.nq[N_W-2:0], 1'b0};
      if (t >= {1'b0, o.den}) begin
        t       = t - {1'b0, o.den};
        o.nq[0] = 1'b1;
      end
      o.rem = t[DEN_W-1:0];
    end
    return o;
  endfunction

  assign in_ready = !v_r || out_ready;

  always_comb begin
    dv_nxt    = in_dv;
    dv_nxt.lx = div_steps(in_dv.lx);
    dv_nxt.ly = div_steps(in_dv.ly);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (in_ready) v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) dv_r <= dv_nxt;
  end

  assign out_valid = v_r;
  assign out_dv    = dv_r;

endmodule

/* rtl/quadratic_root_solver.sv */
// quadratic_root_solver: pipelined solver for a*x^2 + b*x + c = 0.
// Depends on qrs_pkg, qrs_in_if, qrs_out_if, qrs_front, qrs_sqrt_stage,
// qrs_div_stage.
//
// Usage: drive one request of signed coefficients on in_ch (valid/ready);
// each request yields exactly one result on out_ch: a class code
// (infinite, none, linear, double, two real, complex pair) and two signed
// values with 16 fraction bits, truncated toward zero.
// From acceptance to out_ch.valid: 2 front stages (products, discriminant),
// 11 square-root stages of three bit pairs each, 1 numerator stage, 9
// divider stages of four quotient bits each, and the output register.
// Throughput: one request per cycle while out_ch.ready is high. Each stage
// holds its own valid bit and takes a new request when it is empty or its
// successor takes its content.
// Stall: when out_ch.ready is low the result holds in the output register;
// upstream stages keep filling bubbles and in_ch.ready drops only once every
// stage holds a request. Nothing is lost or repeated.
// Reset: rst_n (synchronous, active low) clears all valid bits; the pipe
// is empty and ready in the first cycle after reset.
module quadratic_root_solver (
  input  logic      clk,
  input  logic      rst_n,
  qrs_in_if.sink    in_ch,
  qrs_out_if.source out_ch
);
  import qrs_pkg::*;

  // sqrt chain links: link 0 from the front end, link SQ_STAGES to numerators
  logic    sq_v   [0:SQ_STAGES];
  logic    sq_rdy [0:SQ_STAGES];
  qrs_sq_t sq_p   [0:SQ_STAGES];

  // divider chain links
  logic    dv_v   [0:DIV_STAGES];
  logic    dv_rdy [0:DIV_STAGES];
  qrs_dv_t dv_p   [0:DIV_STAGES];

  qrs_coef_t in_coef;

  logic    vn_r;
  qrs_dv_t dvn_r, dvn_nxt;

  logic                    out_valid_r;
  qrs_class_t              out_cls_r;
  logic signed [VAL_W-1:0] out_first_r, out_first_nxt;
  logic signed [VAL_W-1:0] out_second_r, out_second_nxt;
  logic                    out_take;

  assign in_coef.a = in_ch.coef_a;
  assign in_coef.b = in_ch.coef_b;
  assign in_coef.c = in_ch.coef_c;

  qrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_coef   (in_coef),
    .out_valid (sq_v[0]),
    .out_ready (sq_rdy[0]),
    .out_sq    (sq_p[0])
  );

  // Square root: most significant bit pairs first.
  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sqrt
    qrs_sqrt_stage #(
      .TOP_PAIR (SQ_STAGES * SQ_STEPS - 1 - i * SQ_STEPS)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[i]),
      .in_ready  (sq_rdy[i]),
      .in_sq     (sq_p[i]),
      .out_valid (sq_v[i+1]),
      .out_ready (sq_rdy[i+1]),
      .out_sq    (sq_p[i+1])
    );
  end

  // Numerator stage: pick dividend/divisor per class, split into sign and
  // magnitude so the divider works on unsigned values.
  function automatic logic [N_W-1:0] mag_n(input logic signed [N_W-1:0] v);
    return v[N_W-1] ? N_W'(-v) : N_W'(v);
  endfunction

  always_comb begin
    qrs_sq_t                 s;
    logic signed [N_W-1:0]   bx, cx, nb, nc, sx, nx, ny;
    logic signed [COEF_BITS:0] ax, bxs;
    logic [COEF_BITS:0]      absa, absb;
    logic [DEN_W-1:0]        den2a;
    s     = sq_p[SQ_STAGES];
    bx    = N_W'(s.coef.b);
    cx    = N_W'(s.coef.c);
    nb    = -(bx <<< FRAC_BITS);
    nc    = -(cx <<< FRAC_BITS);
    sx    = N_W'(s.root);
    ax    = (COEF_BITS + 1)'(s.coef.a);
    bxs   = (COEF_BITS + 1)'(s.coef.b);
    absa  = ax[COEF_BITS] ? (COEF_BITS + 1)'(-ax) : (COEF_BITS + 1)'(ax);
    absb  = bxs[COEF_BITS] ? (COEF_BITS + 1)'(-bxs) : (COEF_BITS + 1)'(bxs);
    den2a = {absa[COEF_BITS-1:0], 1'b0};
    nx    = '0;
    ny    = '0;
    dvn_nxt        = '0;
    dvn_nxt.cls    = s.cls;
    dvn_nxt.lx.den = DEN_W'(1);
    dvn_nxt.ly.den = DEN_W'(1);
    case (s.cls)
      CLS_LINEAR: begin
        nx             = nc;
        dvn_nxt.lx.den = absb;
        dvn_nxt.lx.neg = nc[N_W-1] ^ s.coef.b[COEF_BITS-1];
      end
      CLS_DOUBLE: begin
        nx             = nb;
        dvn_nxt.lx.den = den2a;
        dvn_nxt.lx.neg = nb[N_W-1] ^ s.coef.a[COEF_BITS-1];
      end
      CLS_TWO_REAL: begin
        nx             = nb + sx;
        ny             = nb - sx;
        dvn_nxt.lx.den = den2a;
        dvn_nxt.ly.den = den2a;
        dvn_nxt.lx.neg = nx[N_W-1] ^ s.coef.a[COEF_BITS-1];
        dvn_nxt.ly.neg = ny[N_W-1] ^ s.coef.a[COEF_BITS-1];
      end
      CLS_COMPLEX: begin
        nx             = nb;
        ny             = sx;
        dvn_nxt.lx.den = den2a;
        dvn_nxt.ly.den = den2a;
        dvn_nxt.lx.neg = nb[N_W-1] ^ s.coef.a[COEF_BITS-1];
      end
      default: begin
        nx = '0;
        ny = '0;
      end
    endcase
    dvn_nxt.lx.nq = mag_n(nx);
    dvn_nxt.ly.nq = mag_n(ny);
  end

  assign sq_rdy[SQ_STAGES] = !vn_r || dv_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) vn_r <= 1'b0;
    else if (sq_rdy[SQ_STAGES]) vn_r <= sq_v[SQ_STAGES];
  end

  always_ff @(posedge clk) begin
    if (sq_v[SQ_STAGES] && sq_rdy[SQ_STAGES]) dvn_r <= dvn_nxt;
  end

  assign dv_v[0] = vn_r;
  assign dv_p[0] = dvn_r;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    qrs_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_v[i]),
      .in_ready  (dv_rdy[i]),
      .in_dv     (dv_p[i]),
      .out_valid (dv_v[i+1]),
      .out_ready (dv_rdy[i+1]),
      .out_dv    (dv_p[i+1])
    );
  end

  // Output register: restore signs, truncate to the field width.
  always_comb begin
    logic [N_W-1:0] qx, qy;
    qx = dv_p[DIV_STAGES].lx.nq;
    qy = dv_p[DIV_STAGES].ly.nq;
    if (dv_p[DIV_STAGES].lx.neg) qx = N_W'(-qx);
    if (dv_p[DIV_STAGES].ly.neg) qy = N_W'(-qy);
    out_first_nxt  = qx[VAL_W-1:0];
    out_second_nxt = qy[VAL_W-1:0];
  end

  assign out_take           = !out_valid_r || out_ch.ready;
  assign dv_rdy[DIV_STAGES] = out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_take) out_valid_r <= dv_v[DIV_STAGES];
  end

  always_ff @(posedge clk) begin
    if (dv_v[DIV_STAGES] && out_take) begin
      out_cls_r    <= dv_p[DIV_STAGES].cls;
      out_first_r  <= out_first_nxt;
      out_second_r <= out_second_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.root_class   = out_cls_r;
  assign out_ch.first_value  = out_first_r;
  assign out_ch.second_value = out_second_r;

  // Degenerate classes carry zero values.
  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_cls_r == CLS_INFINITE || out_cls_r == CLS_NONE)
    |-> out_first_r == '0 && out_second_r == '0)
    else $error("degenerate class with nonzero value");

  // Single-root classes leave the second value at zero.
  a_single_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_cls_r == CLS_LINEAR || out_cls_r == CLS_DOUBLE)
    |-> out_second_r == '0)
    else $error("single-root class with nonzero second value");

  // Imaginary magnitude never negative.
  a_complex_imag_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cls_r == CLS_COMPLEX |-> !out_second_r[VAL_W-1])
    else $error("negative imaginary magnitude");

endmodule

/* test/quadratic_root_solver_tb.sv */
// quadratic_root_solver_tb: self-checking bench for the pipelined quadratic
// root solver. Depends on qrs_pkg, qrs_in_if, qrs_out_if and the RTL top.
module quadratic_root_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qrs_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] a;
    logic signed [COEF_BITS-1:0] b;
    logic signed [COEF_BITS-1:0] c;
  } coef_set_t;

  typedef struct packed {
    qrs_class_t              cls;
    logic signed [VAL_W-1:0] v1;
    logic signed [VAL_W-1:0] v2;
  } root_set_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  qrs_in_if  in_ch();
  qrs_out_if out_ch();

  quadratic_root_solver uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #2 clk = ~clk;

  coef_set_t pending_coefs[$];
  root_set_t expected_roots[$];
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  failed = 1'b0;
  int  quiet_cycles = 0;

  // Integer square root of d * 2^(2*FRAC_BITS), floored.
  function automatic longint unsigned scaled_root(longint unsigned d);
    longint unsigned root;
    longint unsigned rem;
    longint unsigned pair;
    longint unsigned trial;
    root = 0;
    rem = 0;
    for (int i = 31 + FRAC_BITS; i >= 0; i--) begin
      pair = (i >= FRAC_BITS) ? ((d >> (2 * (i - FRAC_BITS))) & 3) : 0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Predict class and both values; SV division truncates toward zero.
  function automatic root_set_t solve_roots(coef_set_t k);
    root_set_t r;
    longint a, b, c, one, disc, nb, den, s;
    a = k.a;
    b = k.b;
    c = k.c;
    one = longint'(1) << FRAC_BITS;
    r.v1 = '0;
    r.v2 = '0;
    if (a == 0 && b == 0 && c == 0) begin
      r.cls = CLS_INFINITE;
    end else if (a == 0 && b == 0) begin
      r.cls = CLS_NONE;
    end else if (a == 0) begin
      r.cls = CLS_LINEAR;
      r.v1 = VAL_W'((-c * one) / b);
    end else begin
      disc = b * b - 4 * a * c;
      nb = -b * one;
      den = 2 * a;
      if (disc == 0) begin
        r.cls = CLS_DOUBLE;
        r.v1 = VAL_W'(nb / den);
      end else if (disc > 0) begin
        s = longint'(scaled_root(disc));
        r.cls = CLS_TWO_REAL;
        r.v1 = VAL_W'((nb + s) / den);
        r.v2 = VAL_W'((nb - s) / den);
      end else begin
        s = longint'(scaled_root(-disc));
        r.cls = CLS_COMPLEX;
        r.v1 = VAL_W'(nb / den);
        r.v2 = VAL_W'(s / (a < 0 ? -den : den));
      end
    end
    return r;
  endfunction

  function automatic logic signed [COEF_BITS-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return COEF_BITS'($urandom_range(0, 6)) - 3;
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return COEF_BITS'($urandom_range(0, 64)) - 32;
      default: return COEF_BITS'($urandom);
    endcase
  endfunction

  // Queue one request; class mix is steered so every branch gets traffic.
  task automatic push_random();
    coef_set_t k;
    int m;
    k.a = rand_coef();
    k.b = rand_coef();
    k.c = rand_coef();
    case ($urandom_range(0, 9))
      0: k.a = '0;
      1: begin
        // perfect square a*(x + m)^2, gives a double root
        m = $urandom_range(0, 32);
        k.a = COEF_BITS'($urandom_range(1, 31));
        if ($urandom_range(0, 1) != 0) k.a = -k.a;
        k.b = COEF_BITS'(2 * k.a * m);
        k.c = COEF_BITS'(k.a * m * m);
      end
      2: begin
        k.a = '0;
        k.b = '0;
      end
      default: ;
    endcase
    pending_coefs.push_back(k);
  endtask

  task automatic push_coef(int a, int b, int c);
    pending_coefs.push_back({COEF_BITS'(a), COEF_BITS'(b), COEF_BITS'(c)});
  endtask

  // Driver: advance to the next pending request once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.coef_a <= '0;
      in_ch.coef_b <= '0;
      in_ch.coef_c <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_coefs.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
        coef_set_t k;
        k = pending_coefs.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.coef_a <= k.a;
        in_ch.coef_b <= k.b;
        in_ch.coef_c <= k.c;
        expected_roots.push_back(solve_roots(k));
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      out_ch.ready <= ($urandom_range(1, 100) > recv_stall_pct);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_roots.size() == 0) begin
          $error("result with no request waiting");
          failed = 1'b1;
        end else begin
          root_set_t e;
          e = expected_roots.pop_front();
          if (out_ch.root_class !== e.cls) begin
            $error("root_class: expected %0d, actual %0d", e.cls, out_ch.root_class);
            failed = 1'b1;
          end
          if (out_ch.first_value !== e.v1) begin
            $error("first_value: expected %0d, actual %0d", e.v1, out_ch.first_value);
            failed = 1'b1;
          end
          if (out_ch.second_value !== e.v2) begin
            $error("second_value: expected %0d, actual %0d", e.v2, out_ch.second_value);
            failed = 1'b1;
          end
        end
      end
    end else begin
      out_ch.ready <= 1'b0;
    end
  end

  // Watchdog: drop the run when nothing moves for too long.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("quadratic_root_solver: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every class, field extremes, zero b or c with nonzero a.
    push_coef(0, 0, 0);
    push_coef(0, 0, 5);
    push_coef(0, 0, -32768);
    push_coef(0, 3, 7);
    push_coef(0, -32768, 32767);
    push_coef(0, 1, -32768);
    push_coef(1, 2, 1);
    push_coef(-4, 4, -1);
    push_coef(1, 0, -4);
    push_coef(1, 0, 4);
    push_coef(2, 5, 0);
    push_coef(1, -3, 2);
    push_coef(1, 1, 1);
    push_coef(32767, 32767, 32767);
    push_coef(-32768, -32768, -32768);
    push_coef(-32768, 32767, 32767);
    push_coef(32767, -32768, -32768);
    push_coef(1, -32768, -32768);
    push_coef(-32768, 0, 32767);
    push_coef(1, 0, 0);
    push_coef(-1, -1, -1);
    push_coef(-32768, 0, -32768);

    // Random phases: free flow, slow sender, slow receiver, both slow.
    for (int phase = 0; phase < 5; phase++) begin
      wait (pending_coefs.size() == 0);
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 290; i++) push_random();
    end

    wait (pending_coefs.size() == 0 && !in_ch.valid);
    wait (expected_roots.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && expected_roots.size() == 0) begin
      $display("quadratic_root_solver: match");
    end else begin
      $display("quadratic_root_solver: mismatch");
    end
    $finish;
  end
endmodule
